[sv/mhc_pkg.sv]
// Shared types and constants of the mining header cursor.
package mhc_pkg;

  localparam int COUNTER_BYTES = 8;
  localparam int CNT_W         = 8 * COUNTER_BYTES;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROLL_MASK        = 3'd0,
    CFG_HOST_ROLLS_VER   = 3'd1,
    CFG_HOST_ROLLS_EXTRA = 3'd2,
    CFG_JOB_SLOT_COUNT   = 3'd3,
    CFG_HOST_BIT_LIMIT   = 3'd4,
    CFG_EXTRANONCE_LEN   = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic        action;
    logic [7:0]  step_count;
  } in_item_t;

  typedef struct packed {
    logic [30:0] window_index;
    logic [63:0] extranonce_value;
    logic [31:0] window_total;
    logic [31:0] host_mask;
    logic [31:0] chip_mask;
    logic [31:0] host_bits;
    logic        overflowed;
  } out_item_t;

  typedef struct packed {
    logic [31:0] roll_mask;
    logic        host_rolls_version;
    logic        host_rolls_extranonce;
    logic [3:0]  job_slot_count;
    logic [4:0]  host_bit_limit;
    logic [3:0]  extranonce_length;
  } cfg_t;

  typedef struct packed {
    logic        clear;
    logic [7:0]  steps;
  } cmd_t;

endpackage

[sv/mining_header_cursor_top.sv]
// Top level of the mining header cursor: configuration registers and the two halves.
//
// Input side is a queue: drive in_item_i and raise push while full is low to hand
// over an item (action: advance, or clear then advance; step_count: steps to apply).
// Result side is a queue too: while empty is low, out_item_o holds the oldest
// result; raise pop to take it. Every item yields exactly one result item.
// Configuration: write register cfg_index_i with cfg_data_i by raising cfg_we_i
// for one cycle; write only while no item is in flight.
// From push to empty going low, an item passes the mask scan, the advance
// steps and the bit placement pass of the back-end sequencer, in that order.
// One item is worked on at a time.
// A two-entry command queue takes items while the sequencer is busy; a held
// result does not stop the sequencer, which waits only when it has a second
// result ready and the first is still not taken.
// Reset clears cursor index, extranonce2 counter, both queues and loads the
// register defaults.
module mining_header_cursor_top
  import mhc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.roll_mask             <= 32'd0;
      cfg_q.host_rolls_version    <= 1'b0;
      cfg_q.host_rolls_extranonce <= 1'b1;
      cfg_q.job_slot_count        <= 4'd1;
      cfg_q.host_bit_limit        <= 5'd10;
      cfg_q.extranonce_length     <= 4'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROLL_MASK:        cfg_q.roll_mask             <= cfg_data_i;
        CFG_HOST_ROLLS_VER:   cfg_q.host_rolls_version    <= cfg_data_i[0];
        CFG_HOST_ROLLS_EXTRA: cfg_q.host_rolls_extranonce <= cfg_data_i[0];
        CFG_JOB_SLOT_COUNT:   cfg_q.job_slot_count        <= cfg_data_i[3:0];
        CFG_HOST_BIT_LIMIT:   cfg_q.host_bit_limit        <= cfg_data_i[4:0];
        CFG_EXTRANONCE_LEN:   cfg_q.extranonce_length     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  mhc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  mhc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .empty_o     (empty),
    .item_o      (out_item_o),
    .pop_i       (pop)
  );

endmodule

[sv/mhc_front.sv]
// Front end: accepts items, classifies them into commands, two-entry command queue.
module mhc_front
  import mhc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_ready_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       wr_en, rd_en;
  cmd_t       cmd_in;

  assign cmd_in.clear = item_i.action;
  assign cmd_in.steps = item_i.step_count;

  assign full_o      = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    case ({wr_en, rd_en})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

[sv/mhc_back.sv]
// Back end: sequencer that scans the mask, applies advance steps and builds the result item.
module mhc_back
  import mhc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_ready_o,
  output logic      empty_o,
  output out_item_t item_o,
  input  logic      pop_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STEP,
    ST_PLACE,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [30:0]      idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic [7:0]       steps_q;
  logic [4:0]       bit_q;
  logic [4:0]       k_q;
  logic [31:0]      hmask_q;
  logic [30:0]      shreg_q;
  logic [31:0]      hbits_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic [4:0]       limit;
  logic [31:0]      total;
  logic [30:0]      total_mask;
  logic [31:0]      idx_inc;
  logic [30:0]      idx_out;
  logic             ovf;
  logic             out_load;
  out_item_t        out_d;

  assign limit      = (cfg_i.host_rolls_version && (cfg_i.job_slot_count > 4'd1))
                      ? cfg_i.host_bit_limit : 5'd0;
  assign total      = 32'd1 << k_q;
  assign total_mask = 31'(total - 32'd1);
  assign idx_inc    = {1'b0, idx_q & total_mask} + 32'd1;
  assign idx_out    = cfg_i.host_rolls_version ? (idx_q & total_mask) : '0;

  always_comb begin
    ovf = 1'b0;
    for (int i = 0; i < COUNTER_BYTES; i++) begin
      if ((4'(i) >= cfg_i.extranonce_length) && (cnt_q[8*i +: 8] != 8'd0)) begin
        ovf = 1'b1;
      end
    end
  end

  always_comb begin
    out_d.window_index     = idx_out;
    out_d.extranonce_value = cfg_i.host_rolls_extranonce ? 64'(cnt_q) : 64'd0;
    out_d.window_total     = total;
    out_d.host_mask        = hmask_q;
    out_d.chip_mask        = cfg_i.roll_mask & ~hmask_q;
    out_d.host_bits        = hbits_q;
    out_d.overflowed       = ovf;
  end

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || pop_i);
  assign empty_o     = !out_valid_q;
  assign item_o      = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      steps_q     <= '0;
      bit_q       <= '0;
      k_q         <= '0;
      hmask_q     <= '0;
      shreg_q     <= '0;
      hbits_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.clear) begin
              idx_q <= '0;
              cnt_q <= '0;
            end
            steps_q <= cmd_i.steps;
            bit_q   <= '0;
            k_q     <= '0;
            hmask_q <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cfg_i.roll_mask[bit_q] && (k_q < limit)) begin
            hmask_q[bit_q] <= 1'b1;
            k_q            <= k_q + 5'd1;
          end
          if (bit_q == 5'd31) begin
            state_q <= ST_STEP;
          end
          bit_q <= bit_q + 5'd1;
        end
        ST_STEP: begin
          if (steps_q != 8'd0) begin
            steps_q <= steps_q - 8'd1;
            if (idx_inc == total) begin
              idx_q <= '0;
              if (cfg_i.host_rolls_extranonce) begin
                cnt_q <= cnt_q + CNT_W'(1);
              end
            end else begin
              idx_q <= idx_inc[30:0];
            end
          end else begin
            shreg_q <= idx_out;
            hbits_q <= '0;
            bit_q   <= '0;
            state_q <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          if (hmask_q[bit_q]) begin
            hbits_q[bit_q] <= shreg_q[0];
            shreg_q        <= shreg_q >> 1;
          end
          if (bit_q == 5'd31) begin
            state_q <= ST_DONE;
          end
          bit_q <= bit_q + 5'd1;
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
